/* rtl/sfsb_pkg.sv */
// Package for the steered filter-and-sum beamformer: sizes, codes and item types.
package sfsb_pkg;

  localparam int CHANNEL_COUNT = 4;
  localparam int NUM_BINS      = 129;
  localparam int MAX_ANGLES    = 64;

  localparam int STORE_DEPTH = MAX_ANGLES * NUM_BINS * CHANNEL_COUNT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int DEG_W     = 9;
  localparam int BIN_W     = 8;
  localparam int CH_W      = 2;
  localparam int SIN_W     = 10;
  localparam int X_W       = 24;
  localparam int W_W       = 18;
  localparam int PROD_W    = W_W + X_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int ACC_W     = 44;
  localparam int ACC_EXT_W = ACC_W + 1;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 3;

  // (count-1)*deg + 180 fits 15 bits; /360 done as (n>>3)*2913>>17, exact over that range
  localparam int NPROD_W       = 15;
  localparam int DIV_PRE_SHIFT = 3;
  localparam int NQ_W          = NPROD_W - DIV_PRE_SHIFT;
  localparam int QP_W          = 2 * NQ_W;
  localparam int DIV_SHIFT     = 17;
  localparam logic [NQ_W-1:0] DIV_MUL = NQ_W'(2913);

  localparam logic [DEG_W-1:0] DEG_FULL = DEG_W'(360);
  localparam logic [DEG_W-1:0] DEG_HALF = DEG_W'(180);

  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_HEADER = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  localparam logic [1:0] MODE_FIXED  = 2'd0;
  localparam logic [1:0] MODE_INDEX  = 2'd1;
  localparam logic [1:0] MODE_DEGREE = 2'd2;

  localparam logic KIND_BEAM   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_INDEX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_TRACKING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIX_BEAM      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_MIRROR   = 3'd6;

  typedef struct packed {
    logic [1:0]              command;
    logic [IDX_W-1:0]        angle_sel;
    logic [BIN_W-1:0]        bin;
    logic [CH_W-1:0]         channel;
    logic signed [X_W-1:0]   sample_re;
    logic signed [X_W-1:0]   sample_im;
    logic [SIN_W-1:0]        steer_index_in;
    logic [DEG_W-1:0]        beam_degree;
    logic [DEG_W-1:0]        head_degree;
    logic                    calibrate_now;
    logic                    fix_now;
  } item_t;

  typedef struct packed {
    logic                    result_kind;
    logic [BIN_W-1:0]        bin_out;
    logic signed [ACC_W-1:0] beam_re;
    logic signed [ACC_W-1:0] beam_im;
    logic [IDX_W-1:0]        steer_index_out;
    logic [DEG_W-1:0]        head_angle_out;
  } result_t;

endpackage

/* rtl/steered_filter_and_sum_beamformer.sv */
// Steered filter-and-sum beamformer: steering select, weight store and complex MAC.
//
//   channel  | signals                              | moves
//   ---------+--------------------------------------+----------------------------------
//   item     | item_valid, item_stall, item         | weight write, frame header, sample
//   result   | result_valid, result_stall, result   | beam bin or frame report
//   config   | cfg_wen, cfg_index, cfg_data         | one register write per cycle
//
// One item per cycle unless result_stall backs up; path: r1, p2 to p7, result.
// The rate is set by the single weight-store access per item and the single-register
// accumulator loop. Seven stages hold items and collapse bubbles under stall.
// rst is synchronous; the weight store has no reset and needs no clearing pass.
// item_stall rises only when stage 1 is full and cannot move forward.
module steered_filter_and_sum_beamformer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  sfsb_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output sfsb_pkg::result_t               result,
  input  logic                            cfg_wen,
  input  logic [sfsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfsb_pkg::CFG_W-1:0]      cfg_data
);
  import sfsb_pkg::*;

  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_HEADER = 2'd2;
  localparam logic [1:0] OP_SAMPLE = 2'd3;

  typedef struct packed {
    logic [1:0]            op;
    logic                  deg_mode;
    logic [IDX_W-1:0]      idx;
    logic [DEG_W-1:0]      head;
    logic [DEG_W-1:0]      deg;
    logic [NPROD_W-1:0]    nprod;
    logic [BIN_W-1:0]      bin;
    logic [CH_W-1:0]       ch;
    logic [IDX_W-1:0]      asel;
    logic signed [X_W-1:0] xr;
    logic signed [X_W-1:0] xi;
    logic [DEG_W-1:0]      beam;
    logic                  fix_now;
  } pipe_t;

  function automatic logic [W_W-1:0] sat_w(input logic signed [X_W-1:0] x);
    logic fits;
    fits = (&x[X_W-1:W_W-1]) || !(|x[X_W-1:W_W-1]);
    if (fits) return x[W_W-1:0];
    return x[X_W-1] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    if (v[ACC_W] != v[ACC_W-1]) begin
      return v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return v[ACC_W-1:0];
  endfunction

  // configuration
  logic [1:0]       angle_mode;
  logic [IDX_W-1:0] fixed_index;
  logic [CNT_W-1:0] angle_count;
  logic             head_tracking_on;
  logic             calibrate_on;
  logic             fix_beam_on;
  logic             head_mirror_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_mode       <= MODE_FIXED;
      fixed_index      <= '0;
      angle_count      <= CNT_W'(MAX_ANGLES);
      head_tracking_on <= 1'b0;
      calibrate_on     <= 1'b0;
      fix_beam_on      <= 1'b0;
      head_mirror_on   <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_ANGLE_MODE:    angle_mode       <= cfg_data[1:0];
        CFG_FIXED_INDEX:   fixed_index      <= cfg_data[IDX_W-1:0];
        CFG_ANGLE_COUNT:   angle_count      <= cfg_data[CNT_W-1:0];
        CFG_HEAD_TRACKING: head_tracking_on <= cfg_data[0];
        CFG_CALIBRATE:     calibrate_on     <= cfg_data[0];
        CFG_FIX_BEAM:      fix_beam_on      <= cfg_data[0];
        CFG_HEAD_MIRROR:   head_mirror_on   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // top usable steering index
  logic [IDX_W-1:0] eff_c;

  always_comb begin
    if (angle_count == '0) begin
      eff_c = '0;
    end else if (angle_count > CNT_W'(MAX_ANGLES)) begin
      eff_c = IDX_W'(MAX_ANGLES - 1);
    end else begin
      eff_c = IDX_W'(angle_count - CNT_W'(1));
    end
  end

  // pipeline control
  logic [7:1] vld;
  logic [7:1] go;
  logic       res7;
  logic       accept;
  item_t      r1;
  pipe_t      p2, p3, p4, p5, p6, p7;
  pipe_t      p3_next, p4_next, p5_next;

  assign res7 = (p7.op == OP_HEADER) ||
                ((p7.op == OP_SAMPLE) && (p7.ch == CH_W'(CHANNEL_COUNT - 1)));

  always_comb begin
    go[7] = vld[7] && (!res7 || !result_valid || !result_stall);
    for (int k = 6; k >= 1; k--) begin
      go[k] = vld[k] && (!vld[k+1] || go[k+1]);
    end
  end

  assign item_stall = vld[1] && !go[1];
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld[1] <= accept || (vld[1] && !go[1]);
      for (int k = 2; k <= 7; k++) begin
        vld[k] <= go[k-1] || (vld[k] && !go[k]);
      end
    end
  end

  // stage 1: decode, clamp, head angle
  logic [DEG_W-1:0] north_reference;
  logic [1:0]       op1;
  logic             deg1;
  logic [IDX_W-1:0] pre_idx1;
  logic [DEG_W-1:0] hd_mod, north_used, head0, head1;
  logic [DEG_W:0]   hdiff;
  logic             cal1;

  always_ff @(posedge clk) begin
    if (accept) r1 <= item;
  end

  always_comb begin
    op1 = OP_NONE;
    case (r1.command)
      CMD_WEIGHT: if (32'(r1.bin) < NUM_BINS && 32'(r1.channel) < CHANNEL_COUNT &&
                      32'(r1.angle_sel) < MAX_ANGLES) op1 = OP_WRITE;
      CMD_HEADER: op1 = OP_HEADER;
      CMD_SAMPLE: if (32'(r1.bin) < NUM_BINS && 32'(r1.channel) < CHANNEL_COUNT)
                    op1 = OP_SAMPLE;
      default:    op1 = OP_NONE;
    endcase

    deg1 = (angle_mode == MODE_DEGREE);

    if (angle_mode == MODE_INDEX) begin
      pre_idx1 = (r1.steer_index_in > SIN_W'(eff_c)) ? eff_c : r1.steer_index_in[IDX_W-1:0];
    end else begin
      pre_idx1 = (fixed_index > eff_c) ? eff_c : fixed_index;
    end

    hd_mod     = (r1.head_degree >= DEG_FULL) ? r1.head_degree - DEG_FULL : r1.head_degree;
    cal1       = deg1 && head_tracking_on && calibrate_on && r1.calibrate_now;
    north_used = cal1 ? hd_mod : north_reference;
    hdiff      = {1'b0, hd_mod} - {1'b0, north_used};
    head0      = hdiff[DEG_W] ? DEG_W'(hdiff + {1'b0, DEG_FULL}) : hdiff[DEG_W-1:0];
    if (head_mirror_on && head0 != '0) begin
      head1 = DEG_FULL - head0;
    end else begin
      head1 = head0;
    end
    if (!(deg1 && head_tracking_on)) head1 = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      north_reference <= '0;
    end else if (go[1] && op1 == OP_HEADER && cal1) begin
      north_reference <= hd_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (go[1]) begin
      p2.op       <= op1;
      p2.deg_mode <= deg1;
      p2.idx      <= pre_idx1;
      p2.head     <= head1;
      p2.deg      <= '0;
      p2.nprod    <= '0;
      p2.bin      <= r1.bin;
      p2.ch       <= r1.channel;
      p2.asel     <= r1.angle_sel;
      p2.xr       <= r1.sample_re;
      p2.xi       <= r1.sample_im;
      p2.beam     <= r1.beam_degree;
      p2.fix_now  <= r1.fix_now;
    end
  end

  // stage 2: beam degree and fix-beam hold
  logic [DEG_W-1:0] held_beam_degree;
  logic [DEG_W-1:0] beam_mod, deg_calc, deg2;
  logic [DEG_W+1:0] tdeg;
  logic             hold_wr;

  always_comb begin
    beam_mod = (p2.beam >= DEG_FULL) ? p2.beam - DEG_FULL : p2.beam;
    tdeg     = {2'b0, beam_mod} + {2'b0, DEG_HALF} - {2'b0, p2.head};
    if (tdeg[DEG_W+1]) begin
      deg_calc = DEG_W'(tdeg + {2'b0, DEG_FULL});
    end else if (tdeg[DEG_W:0] >= {1'b0, DEG_FULL}) begin
      deg_calc = DEG_W'(tdeg - {2'b0, DEG_FULL});
    end else begin
      deg_calc = tdeg[DEG_W-1:0];
    end
    if (!fix_beam_on) begin
      deg2 = '0;
    end else if (p2.fix_now) begin
      deg2 = held_beam_degree;
    end else begin
      deg2 = deg_calc;
    end
    hold_wr = go[2] && p2.op == OP_HEADER && p2.deg_mode && fix_beam_on && !p2.fix_now;
    p3_next     = p2;
    p3_next.deg = deg2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_beam_degree <= '0;
    end else if (hold_wr) begin
      held_beam_degree <= deg_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (go[2]) p3 <= p3_next;
  end

  // stage 3: (count-1)*deg + 180
  logic [NPROD_W-1:0] nprod3;

  assign nprod3 = NPROD_W'(NPROD_W'(eff_c) * NPROD_W'(p3.deg)) + NPROD_W'(DEG_HALF);

  always_comb begin
    p4_next       = p3;
    p4_next.nprod = nprod3;
  end

  always_ff @(posedge clk) begin
    if (go[3]) p4 <= p4_next;
  end

  // stage 4: divide by 360, steering update, weight store access
  logic [IDX_W-1:0]   steer_index;
  logic [QP_W-1:0]    qprod;
  logic [IDX_W:0]     q4;
  logic [IDX_W-1:0]   idx_hdr, ang4;
  logic [ADDR_W-1:0]  addr4;
  logic [2*W_W-1:0]   wdata4;
  logic [2*W_W-1:0]   wstore [STORE_DEPTH];
  logic [2*W_W-1:0]   rdata;

  always_comb begin
    qprod   = {{(QP_W-NQ_W){1'b0}}, p4.nprod[NPROD_W-1:DIV_PRE_SHIFT]} *
              {{(QP_W-NQ_W){1'b0}}, DIV_MUL};
    q4      = qprod[DIV_SHIFT+IDX_W:DIV_SHIFT];
    if (!p4.deg_mode) begin
      idx_hdr = p4.idx;
    end else if (q4 > {1'b0, eff_c}) begin
      idx_hdr = eff_c;
    end else begin
      idx_hdr = q4[IDX_W-1:0];
    end
    ang4   = (p4.op == OP_WRITE) ? p4.asel : steer_index;
    addr4  = ADDR_W'((32'(ang4) * NUM_BINS + 32'(p4.bin)) * CHANNEL_COUNT + 32'(p4.ch));
    wdata4 = {sat_w(p4.xr), sat_w(p4.xi)};
    p5_next     = p4;
    p5_next.idx = (p4.op == OP_HEADER) ? idx_hdr : steer_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_index <= '0;
    end else if (go[4] && p4.op == OP_HEADER) begin
      steer_index <= idx_hdr;
    end
  end

  always_ff @(posedge clk) begin
    if (go[4]) begin
      if (p4.op == OP_WRITE) wstore[addr4] <= wdata4;
      rdata <= wstore[addr4];
    end
  end

  always_ff @(posedge clk) begin
    if (go[4]) p5 <= p5_next;
  end

  // stage 5: conj(w) * x partial products
  logic signed [W_W-1:0]    wr5, wi5;
  logic signed [PROD_W-1:0] prr, pii, pri, pir;

  assign wr5 = rdata[2*W_W-1:W_W];
  assign wi5 = rdata[W_W-1:0];

  always_ff @(posedge clk) begin
    if (go[5]) begin
      p6  <= p5;
      prr <= wr5 * p5.xr;
      pii <= wi5 * p5.xi;
      pri <= wr5 * p5.xi;
      pir <= wi5 * p5.xr;
    end
  end

  // stage 6: sum partial products
  logic signed [SUM_W-1:0] s_re, s_im;

  always_ff @(posedge clk) begin
    if (go[6]) begin
      p7   <= p6;
      s_re <= SUM_W'(prr) + SUM_W'(pii);
      s_im <= SUM_W'(pri) - SUM_W'(pir);
    end
  end

  // stage 7: saturating accumulate and result
  logic signed [ACC_W-1:0]     acc_re, acc_im;
  logic signed [ACC_W-1:0]     acc_re_next, acc_im_next;
  logic signed [ACC_EXT_W-1:0] add_re, add_im;

  always_comb begin
    add_re      = ACC_EXT_W'(acc_re) + ACC_EXT_W'(s_re);
    add_im      = ACC_EXT_W'(acc_im) + ACC_EXT_W'(s_im);
    acc_re_next = sat_acc(add_re);
    acc_im_next = sat_acc(add_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (go[7]) begin
      if (res7) begin
        acc_re <= '0;
        acc_im <= '0;
      end else if (p7.op == OP_SAMPLE) begin
        acc_re <= acc_re_next;
        acc_im <= acc_im_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go[7] && res7) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go[7] && res7) begin
      result.steer_index_out <= p7.idx;
      if (p7.op == OP_HEADER) begin
        result.result_kind    <= KIND_REPORT;
        result.bin_out        <= '0;
        result.beam_re        <= '0;
        result.beam_im        <= '0;
        result.head_angle_out <= p7.head;
      end else begin
        result.result_kind    <= KIND_BEAM;
        result.bin_out        <= p7.bin;
        result.beam_re        <= acc_re_next;
        result.beam_im        <= acc_im_next;
        result.head_angle_out <= '0;
      end
    end
  end

  // checks
  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    go[7] && res7 |=> acc_re == '0 && acc_im == '0)
    else $error("accumulator not cleared after a result");

  a_angles_in_range: assert property (@(posedge clk) disable iff (rst)
    north_reference < DEG_FULL && held_beam_degree < DEG_FULL)
    else $error("stored angle out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> !(go[7] && res7))
    else $error("result register overwritten while stalled");

endmodule
